FILE: rtl/swrr_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window reward ranker package
// Shared widths, sequencer states and the control word sent along the
// row of rank cells.
// ----------------------------------------------------------------------------
`default_nettype none

package swrr_pkg;

    // Fixed field widths of the ports
    localparam int REWARD_W = 32;
    localparam int OP_ID_W  = 4;
    localparam int RANK_W   = 6;
    localparam int COUNT_W  = 7;
    localparam int SIZE_W   = 7;

    localparam logic [SIZE_W-1:0] WINDOW_SIZE_RESET = 7'd64;

    // Per-word sequence: take word, drop oldest, insert, hand over result
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVICT,
        ST_INSERT,
        ST_FINISH
    } state_t;

    // Broadcast to every rank cell
    typedef struct packed {
        logic                del_en;
        logic                ins_en;
        logic [REWARD_W-1:0] new_reward;
        logic [REWARD_W-1:0] ev_reward;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/swrr_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module swrr_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on enable, read every cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/swrr_cell.sv
// ----------------------------------------------------------------------------
// Rank cell
// Holds the reward and age of the window entry at one rank. On a drop it
// takes its upper neighbour's entry; on an insert it takes the new word,
// its lower neighbour's entry, or keeps its own, and ages by one unless it takes the new word.
// ----------------------------------------------------------------------------
`default_nettype none

module swrr_cell
    import swrr_pkg::*;
#(
    parameter int AW = 6
) (
    input  wire logic                clk,
    input  wire cell_ctrl_t          ctrl,
    input  wire logic                valid,
    input  wire logic [AW-1:0]       oldest_age,
    input  wire logic                prev_ge,
    input  wire logic [REWARD_W-1:0] prev_reward,
    input  wire logic [AW-1:0]       prev_age,
    input  wire logic [REWARD_W-1:0] next_reward,
    input  wire logic [AW-1:0]       next_age,
    output logic                     ge,
    output logic                     insert_here,
    output logic [REWARD_W-1:0]      reward,
    output logic [AW-1:0]            age
);

    logic [REWARD_W-1:0] reward_reg;
    logic [REWARD_W-1:0] reward_next;
    logic [AW-1:0]       age_reg;
    logic [AW-1:0]       age_next;
    logic                take_next;

    // Empty cells rank above any reward, so the insert point is the first edge
    assign ge          = !valid || ($signed(reward_reg) >= $signed(ctrl.new_reward));
    assign insert_here = ge && !prev_ge;

    // Drop: this entry and everything ranked above it move down one place
    assign take_next = valid && ((age_reg == oldest_age) ||
                       ($signed(reward_reg) > $signed(ctrl.ev_reward)));

    always_comb
    begin
        reward_next = reward_reg;
        age_next    = age_reg;
        if (ctrl.del_en && take_next)
        begin
            reward_next = next_reward;
            age_next    = next_age;
        end
        else if (ctrl.ins_en)
        begin
            if (insert_here)
            begin
                reward_next = ctrl.new_reward;
                age_next    = '0;
            end
            else if (prev_ge)
            begin
                reward_next = prev_reward;
                age_next    = prev_age + AW'(1);
            end
            else
            begin
                age_next = age_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        reward_reg <= reward_next;
        age_reg    <= age_next;
    end

    assign reward = reward_reg;
    assign age    = age_reg;

endmodule

`default_nettype wire

FILE: rtl/sliding_window_reward_ranker.sv
// Each word passes the steps take, drop, insert and hand over in turn, run
// by the sequencer that drives the row of rank cells and the one read
// port of the window memory; no new word is taken until the last one is
// handed over, and a stalled result holds the sequencer in its last step.
// Reset clears the sequencer, fill, write pointer, operator counts and
// output valid, and loads a window size of 64; no clearing pass.
// ----------------------------------------------------------------------------
// Sliding window reward ranker
// Keeps the latest rewards in a circular window memory, orders them in a
// row of rank cells, counts entries per operator and reports the rank of
// each new reward together with any dropped entry.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_reward_ranker
    import swrr_pkg::*;
#(
    parameter int WINDOW_MAX     = 64,
    parameter int OPERATOR_COUNT = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [SIZE_W-1:0]          cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [OP_ID_W-1:0]         operator_id,
    input  wire logic signed [REWARD_W-1:0] reward,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [RANK_W-1:0]               insert_rank,
    output logic                            evicted,
    output logic [OP_ID_W-1:0]              evicted_operator,
    output logic signed [REWARD_W-1:0]      evicted_reward,
    output logic [COUNT_W-1:0]              operator_count,
    output logic [SIZE_W-1:0]               fill_level
);

    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int OW = (OPERATOR_COUNT > 1) ? $clog2(OPERATOR_COUNT) : 1;
    localparam int SW = (CW > SIZE_W) ? CW : SIZE_W;
    localparam int EW = OW + REWARD_W;

    // Control registers
    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] window_size_reg;
    logic [CW-1:0]     fill_reg, fill_next;
    logic [AW-1:0]     wp_reg, wp_next;
    logic              evict_reg, evict_next;
    logic [CW-1:0]     cnt_reg [OPERATOR_COUNT];
    logic [CW-1:0]     cnt_next [OPERATOR_COUNT];
    logic              out_valid_reg, out_valid_next;

    // Payload registers
    logic [OW-1:0]       op_reg, op_next;
    logic [REWARD_W-1:0] rw_reg, rw_next;
    logic [OW-1:0]       ev_op_reg, ev_op_next;
    logic [REWARD_W-1:0] ev_rw_reg, ev_rw_next;
    logic [WINDOW_MAX-1:0] onehot_reg, onehot_next;
    logic [RANK_W-1:0]   insert_rank_reg, insert_rank_next;
    logic                evicted_reg, evicted_next;
    logic [OP_ID_W-1:0]  evicted_operator_reg, evicted_operator_next;
    logic [REWARD_W-1:0] evicted_reward_reg, evicted_reward_next;
    logic [COUNT_W-1:0]  operator_count_reg, operator_count_next;
    logic [SIZE_W-1:0]   fill_level_reg, fill_level_next;

    // Window memory and cell row
    logic                ram_we;
    logic [AW-1:0]       ram_raddr;
    logic [EW-1:0]       ram_rdata;
    logic [OW-1:0]       rd_op;
    logic [REWARD_W-1:0] rd_rw;
    cell_ctrl_t          ctrl;
    logic [AW-1:0]       oldest_age;
    logic [WINDOW_MAX-1:0] cell_valid;
    logic [WINDOW_MAX-1:0] cell_ge;
    logic [WINDOW_MAX-1:0] insert_vec;
    logic [REWARD_W-1:0] cell_reward [WINDOW_MAX];
    logic [AW-1:0]       cell_age [WINDOW_MAX];

    // Misc combinational
    logic [OP_ID_W-1:0] op_wrap;
    logic [SW-1:0]      ws_ext;
    logic [SW-1:0]      size_eff;
    logic [CW-1:0]      wp_ext;
    logic [AW-1:0]      pos;

    // Wrap operator id into range
    always_comb
    begin
        op_wrap = operator_id;
        for (int k = 0; k < 8; k++)
        begin
            if (int'(op_wrap) >= OPERATOR_COUNT)
            begin
                op_wrap = op_wrap - OP_ID_W'(OPERATOR_COUNT);
            end
        end
    end

    // Clamp the configured window size
    always_comb
    begin
        ws_ext = SW'(window_size_reg);
        if (ws_ext == '0)
        begin
            size_eff = SW'(1);
        end
        else if (ws_ext > SW'(WINDOW_MAX))
        begin
            size_eff = SW'(WINDOW_MAX);
        end
        else
        begin
            size_eff = ws_ext;
        end
    end

    // Address of the oldest entry: write pointer minus fill, modulo depth
    always_comb
    begin
        wp_ext = CW'(wp_reg);
        if (wp_ext >= fill_reg)
        begin
            ram_raddr = AW'(wp_ext - fill_reg);
        end
        else
        begin
            ram_raddr = AW'(wp_ext + CW'(WINDOW_MAX) - fill_reg);
        end
    end

    assign rd_op      = ram_rdata[EW-1:REWARD_W];
    assign rd_rw      = ram_rdata[REWARD_W-1:0];
    assign oldest_age = AW'(fill_reg - CW'(1));

    swrr_ram #(
        .WIDTH (EW),
        .DEPTH (WINDOW_MAX)
    ) u_window_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata ({op_reg, rw_reg}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Row of rank cells, each linked to both neighbours
    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        localparam int P = (i == 0) ? 0 : i - 1;
        localparam int N = (i == WINDOW_MAX - 1) ? i : i + 1;

        assign cell_valid[i] = (fill_reg > CW'(i));

        swrr_cell #(
            .AW (AW)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .valid       (cell_valid[i]),
            .oldest_age  (oldest_age),
            .prev_ge     ((i == 0) ? 1'b0 : cell_ge[P]),
            .prev_reward (cell_reward[P]),
            .prev_age    (cell_age[P]),
            .next_reward (cell_reward[N]),
            .next_age    (cell_age[N]),
            .ge          (cell_ge[i]),
            .insert_here (insert_vec[i]),
            .reward      (cell_reward[i]),
            .age         (cell_age[i])
        );
    end

    // Encode the registered insert point
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            if (onehot_reg[i])
            begin
                pos = pos | AW'(i);
            end
        end
    end

    // Update operator counts in the drop step: count the new word, uncount the dropped one
    always_comb
    begin
        logic [CW:0] inc_sum;
        logic        dec;
        for (int k = 0; k < OPERATOR_COUNT; k++)
        begin
            inc_sum     = {1'b0, cnt_reg[k]} + (CW+1)'(op_reg == OW'(k));
            dec         = evict_reg && (rd_op == OW'(k)) && (inc_sum != '0);
            cnt_next[k] = cnt_reg[k];
            if (state_reg == ST_EVICT)
            begin
                cnt_next[k] = CW'(inc_sum - (CW+1)'(dec));
            end
        end
    end

    // Sequencer: next state and datapath controls
    always_comb
    begin
        state_next            = state_reg;
        in_ready              = 1'b0;
        op_next               = op_reg;
        rw_next               = rw_reg;
        evict_next            = evict_reg;
        ev_op_next            = ev_op_reg;
        ev_rw_next            = ev_rw_reg;
        fill_next             = fill_reg;
        wp_next               = wp_reg;
        onehot_next           = onehot_reg;
        ram_we                = 1'b0;
        ctrl.del_en           = 1'b0;
        ctrl.ins_en           = 1'b0;
        ctrl.new_reward       = rw_reg;
        ctrl.ev_reward        = rd_rw;
        out_valid_next        = out_valid_reg && !out_ready;
        insert_rank_next      = insert_rank_reg;
        evicted_next          = evicted_reg;
        evicted_operator_next = evicted_operator_reg;
        evicted_reward_next   = evicted_reward_reg;
        operator_count_next   = operator_count_reg;
        fill_level_next       = fill_level_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Take a word; the oldest entry is read in the same edge
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next    = OW'(op_wrap);
                    rw_next    = reward;
                    evict_next = (SW'(fill_reg) >= size_eff);
                    state_next = ST_EVICT;
                end
            end
            ST_EVICT:
            begin
                // Drop the oldest entry from the ranks
                ctrl.del_en = evict_reg;
                ev_op_next  = '0;
                ev_rw_next  = '0;
                if (evict_reg)
                begin
                    ev_op_next = rd_op;
                    ev_rw_next = rd_rw;
                    fill_next  = fill_reg - CW'(1);
                end
                state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                // Insert the new word and advance the window
                ctrl.ins_en = 1'b1;
                onehot_next = insert_vec;
                ram_we      = 1'b1;
                fill_next   = fill_reg + CW'(1);
                wp_next     = (wp_reg == AW'(WINDOW_MAX - 1)) ? '0 : wp_reg + AW'(1);
                state_next  = ST_FINISH;
            end
            ST_FINISH:
            begin
                // Hand over once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next        = 1'b1;
                    insert_rank_next      = RANK_W'(pos);
                    evicted_next          = evict_reg;
                    evicted_operator_next = OP_ID_W'(ev_op_reg);
                    evicted_reward_next   = ev_rw_reg;
                    operator_count_next   = COUNT_W'(cnt_reg[op_reg]);
                    fill_level_next       = SIZE_W'(fill_reg);
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            window_size_reg <= WINDOW_SIZE_RESET;
            fill_reg        <= '0;
            wp_reg          <= '0;
            evict_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int k = 0; k < OPERATOR_COUNT; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            wp_reg        <= wp_next;
            evict_reg     <= evict_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            if (cfg_we)
            begin
                window_size_reg <= cfg_data;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        op_reg               <= op_next;
        rw_reg               <= rw_next;
        ev_op_reg            <= ev_op_next;
        ev_rw_reg            <= ev_rw_next;
        onehot_reg           <= onehot_next;
        insert_rank_reg      <= insert_rank_next;
        evicted_reg          <= evicted_next;
        evicted_operator_reg <= evicted_operator_next;
        evicted_reward_reg   <= evicted_reward_next;
        operator_count_reg   <= operator_count_next;
        fill_level_reg       <= fill_level_next;
    end

    assign out_valid        = out_valid_reg;
    assign insert_rank      = insert_rank_reg;
    assign evicted          = evicted_reg;
    assign evicted_operator = evicted_operator_reg;
    assign evicted_reward   = evicted_reward_reg;
    assign operator_count   = operator_count_reg;
    assign fill_level       = fill_level_reg;

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(WINDOW_MAX))
        else $error("window fill beyond depth");

    a_single_insert_point: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH |-> $onehot(onehot_reg))
        else $error("insert point not unique");

    a_accept_starts_drop: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_EVICT)
        else $error("accepted word did not start a drop step");

    a_drop_shrinks_fill: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EVICT && evict_reg |=> fill_reg == $past(fill_reg) - CW'(1))
        else $error("drop did not shrink fill by one");

    a_result_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("result raised outside the hand-over step");

endmodule

`default_nettype wire
